>>> rtl/terrain_patch_strip_index_generator_defines.svh
// Assertion macros for the terrain patch strip index generator.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef TERRAIN_PATCH_STRIP_INDEX_GENERATOR_DEFINES_SVH
`define TERRAIN_PATCH_STRIP_INDEX_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define TPSIG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("tpsig assertion failed");
`define TPSIG_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("tpsig forbidden condition seen");
`else
`define TPSIG_ASSERT(lbl, clk, rstn, prop)
`define TPSIG_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

>>> rtl/tpsig_pkg.sv
// Shared types and codes for the terrain patch strip index generator.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package tpsig_pkg;

    localparam int ORIGIN_W   = 12;
    localparam int COORD_W    = 13;
    localparam int LOD_W      = 2;
    localparam int REL_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;

    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_X_ORIGIN = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_Z_ORIGIN = 1'b1;

    // neighbour relation; code 3 behaves as coarser
    localparam logic [REL_W-1:0] REL_FINER   = 2'd0;
    localparam logic [REL_W-1:0] REL_SAME    = 2'd1;
    localparam logic [REL_W-1:0] REL_COARSER = 2'd2;

    localparam logic [STATUS_W-1:0] ST_VERTEX = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IDLE   = 2'd2;

    typedef enum logic [4:0] {
        SEC_BODY   = 5'b00001,
        SEC_LINK_R = 5'b00010,
        SEC_RIGHT  = 5'b00100,
        SEC_LINK_U = 5'b01000,
        SEC_UPPER  = 5'b10000
    } sect_t;

    typedef struct packed {
        sect_t             section;
        logic              phase;
        logic [LOD_W-1:0]  lod;
        logic [REL_W-1:0]  right;
        logic [REL_W-1:0]  upper;
    } seq_ctl_t;

endpackage

`default_nettype wire

>>> rtl/tpsig_seq.sv
// Sequencer: held level/relations, section, counters and active flag.
// Depends on tpsig_pkg; feeds tpsig_body and tpsig_edge with the current position.
`default_nettype none

`include "terrain_patch_strip_index_generator_defines.svh"

module tpsig_seq
    import tpsig_pkg::*;
#(
    parameter int EDGE_SQUARES = 16,
    parameter int LEVELS       = 4,
    localparam int OW = $clog2(EDGE_SQUARES + 1),
    localparam int RW = $clog2(2 * EDGE_SQUARES + 2)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                go,
    input  wire logic                opcode,
    input  wire logic [LOD_W-1:0]    lod,
    input  wire logic [REL_W-1:0]    right_rel,
    input  wire logic [REL_W-1:0]    upper_rel,
    output seq_ctl_t                 ctl,
    output logic      [OW-1:0]       col,
    output logic      [RW-1:0]       row,
    output logic      [RW-1:0]       len_r,
    output logic      [RW-1:0]       len_u,
    output logic      [STATUS_W-1:0] status,
    output logic                     last
);

    localparam logic [OW-1:0] S_O = OW'(EDGE_SQUARES);

    logic [LOD_W-1:0] lod_reg, lod_next;
    logic [REL_W-1:0] right_reg, right_next;
    logic [REL_W-1:0] upper_reg, upper_next;
    sect_t            sect_reg, sect_next;
    logic             phase_reg, phase_next;
    logic [OW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic             active_reg, active_next;

    logic             start;
    logic [LOD_W-1:0] lod_sat;
    logic [LOD_W-1:0] cur_lod;
    logic [REL_W-1:0] cur_right, cur_upper;
    sect_t            cur_sect;
    logic             cur_phase;
    logic [OW-1:0]    cur_col;
    logic [RW-1:0]    cur_row;
    logic [OW-1:0]    n_cur;
    logic             empty;
    logic             emit;
    logic [RW:0]      row_inc;

    function automatic logic [RW-1:0] edge_len(input logic [LOD_W-1:0] lv,
                                               input logic [REL_W-1:0] rel);
        logic [RW-1:0] n;
        logic [RW-1:0] h;
        n = RW'(EDGE_SQUARES >> lv);
        h = RW'(EDGE_SQUARES >> (int'(lv) + 1));
        case (rel)
            REL_SAME:  edge_len = (n << 1) + RW'(1);
            REL_FINER: edge_len = (n << 2) + RW'(1);
            default:   edge_len = (h << 2) + RW'(1);
        endcase
    endfunction

    assign start   = (opcode == OP_START);
    assign lod_sat = (int'(lod) > LEVELS - 1) ? LOD_W'(LEVELS - 1) : lod;

    // a start word restarts from the top of the body strip with its own level
    assign cur_lod   = start ? lod_sat   : lod_reg;
    assign cur_right = start ? right_rel : right_reg;
    assign cur_upper = start ? upper_rel : upper_reg;
    assign cur_sect  = start ? SEC_BODY  : sect_reg;
    assign cur_phase = start ? 1'b0      : phase_reg;
    assign cur_col   = start ? '0        : col_reg;
    assign cur_row   = start ? '0        : row_reg;

    assign n_cur = S_O >> cur_lod;
    assign len_r = edge_len(cur_lod, cur_right);
    assign len_u = edge_len(cur_lod, cur_upper);

    assign empty = ((lod_sat == '0) && (right_rel == REL_FINER || upper_rel == REL_FINER))
                   || (n_cur < OW'(2));
    assign emit  = start ? !empty : active_reg;

    assign row_inc = (RW+1)'(cur_row) + (RW+1)'(1);

    assign ctl = '{section: cur_sect, phase: cur_phase, lod: cur_lod,
                   right: cur_right, upper: cur_upper};
    assign col = cur_col;
    assign row = cur_row;

    always_comb begin
        lod_next    = lod_reg;
        right_next  = right_reg;
        upper_next  = upper_reg;
        sect_next   = sect_reg;
        phase_next  = phase_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        active_next = active_reg;
        status      = ST_VERTEX;
        last        = 1'b0;

        if (go && start) begin
            lod_next    = lod_sat;
            right_next  = right_rel;
            upper_next  = upper_rel;
            sect_next   = SEC_BODY;
            phase_next  = 1'b0;
            col_next    = '0;
            row_next    = '0;
            active_next = 1'b0;
        end

        if (go && !emit) begin
            status = start ? ST_EMPTY : ST_IDLE;
        end else if (go) begin
            active_next = 1'b1;
            case (cur_sect)
                SEC_BODY: begin
                    if (!cur_phase) begin
                        phase_next = 1'b1;
                    end else begin
                        phase_next = 1'b0;
                        if (row_inc < (RW+1)'(n_cur)) begin
                            row_next = row_inc[RW-1:0];
                        end else if (row_inc == (RW+1)'(n_cur)) begin
                            // end of a column: step over to the return row or leave the body
                            if ((OW+1)'(cur_col) + (OW+1)'(2) < (OW+1)'(n_cur)) begin
                                row_next = RW'(n_cur);
                            end else begin
                                sect_next = SEC_LINK_R;
                                row_next  = '0;
                                col_next  = '0;
                            end
                        end else begin
                            col_next = cur_col + OW'(1);
                            row_next = '0;
                        end
                    end
                end
                SEC_LINK_R: begin
                    if (!cur_phase) begin
                        phase_next = 1'b1;
                    end else begin
                        phase_next = 1'b0;
                        sect_next  = SEC_RIGHT;
                        row_next   = '0;
                    end
                end
                SEC_RIGHT: begin
                    row_next = row_inc[RW-1:0];
                    if (row_inc >= (RW+1)'(len_r)) begin
                        sect_next  = SEC_LINK_U;
                        row_next   = '0;
                        phase_next = 1'b0;
                    end
                end
                SEC_LINK_U: begin
                    if (!cur_phase) begin
                        phase_next = 1'b1;
                    end else begin
                        phase_next = 1'b0;
                        sect_next  = SEC_UPPER;
                        row_next   = '0;
                    end
                end
                SEC_UPPER: begin
                    row_next = row_inc[RW-1:0];
                    if (row_inc >= (RW+1)'(len_u)) begin
                        last        = 1'b1;
                        active_next = 1'b0;
                        sect_next   = SEC_BODY;
                        row_next    = '0;
                    end
                end
                default: begin
                    active_next = 1'b0;
                    status      = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lod_reg    <= '0;
            right_reg  <= REL_SAME;
            upper_reg  <= REL_SAME;
            sect_reg   <= SEC_BODY;
            phase_reg  <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            active_reg <= 1'b0;
        end else begin
            lod_reg    <= lod_next;
            right_reg  <= right_next;
            upper_reg  <= upper_next;
            sect_reg   <= sect_next;
            phase_reg  <= phase_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            active_reg <= active_next;
        end
    end

    `TPSIG_ASSERT(a_last_ends_run, aclk, aresetn, go && last |=> !active_reg)
    `TPSIG_ASSERT(a_idle_holds, aclk, aresetn, go && status == ST_IDLE |=> $stable(sect_reg) && $stable(row_reg) && !active_reg)
    `TPSIG_ASSERT(a_empty_parks, aclk, aresetn, go && status == ST_EMPTY |=> !active_reg && sect_reg == SEC_BODY)

endmodule

`default_nettype wire

>>> rtl/tpsig_body.sv
// Body strip vertex offsets from the current column, row and phase.
// Depends on tpsig_pkg; used by the top level.
`default_nettype none

module tpsig_body
    import tpsig_pkg::*;
#(
    parameter int EDGE_SQUARES = 16,
    localparam int OW = $clog2(EDGE_SQUARES + 1),
    localparam int RW = $clog2(2 * EDGE_SQUARES + 2)
) (
    input  seq_ctl_t            ctl,
    input  wire logic [OW-1:0]  col,
    input  wire logic [RW-1:0]  row,
    output logic      [OW-1:0]  u,
    output logic      [OW-1:0]  v
);

    localparam logic [OW-1:0] S_O = OW'(EDGE_SQUARES);

    logic [OW-1:0] n;
    logic [OW-1:0] d;
    logic [OW-1:0] a;
    logic [RW-1:0] r;
    logic          ph;
    logic [OW-1:0] ad;
    logic [OW-1:0] rd;

    assign n = S_O >> ctl.lod;
    assign d = OW'(1) << ctl.lod;

    // first degenerate vertex repeats the final body vertex
    always_comb begin
        if (ctl.section == SEC_LINK_R) begin
            a  = n - OW'(2);
            r  = RW'(n - OW'(1));
            ph = 1'b1;
        end else begin
            a  = col;
            r  = row;
            ph = ctl.phase;
        end
    end

    assign ad = a << ctl.lod;
    assign rd = OW'(r) << ctl.lod;

    always_comb begin
        if (r < RW'(n)) begin
            u = ad + (ph ? d : '0);
            v = S_O - d - rd;
        end else begin
            // return row between columns
            u = ad + d;
            v = ph ? (S_O - d) : '0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tpsig_edge.sv
// Right and upper edge stitching vertex offsets, including degenerate links.
// Depends on tpsig_pkg; used by the top level.
`default_nettype none

module tpsig_edge
    import tpsig_pkg::*;
#(
    parameter int EDGE_SQUARES = 16,
    localparam int OW = $clog2(EDGE_SQUARES + 1),
    localparam int RW = $clog2(2 * EDGE_SQUARES + 2)
) (
    input  seq_ctl_t            ctl,
    input  wire logic [RW-1:0]  row,
    input  wire logic [RW-1:0]  len_r,
    input  wire logic [RW-1:0]  len_u,
    output logic      [OW-1:0]  x,
    output logic      [OW-1:0]  z
);

    localparam logic [OW-1:0] S_O = OW'(EDGE_SQUARES);

    logic [REL_W-1:0] rel;
    logic [RW-1:0]    j;
    logic [RW-1:0]    len;
    logic             swap;
    logic [OW-1:0]    d;
    logic [RW-1:0]    jm1;
    logic [OW-1:0]    k_same_d;
    logic [OW-1:0]    k4_d;
    logic [OW-1:0]    xb;
    logic [OW-1:0]    u;
    logic [OW-1:0]    v;

    always_comb begin
        rel  = ctl.right;
        j    = '0;
        len  = len_r;
        swap = 1'b0;
        case (ctl.section)
            SEC_RIGHT: begin
                j = row;
            end
            SEC_LINK_U: begin
                if (!ctl.phase) begin
                    j = len_r - RW'(1);
                end else begin
                    rel  = ctl.upper;
                    len  = len_u;
                    swap = 1'b1;
                end
            end
            SEC_UPPER: begin
                rel  = ctl.upper;
                j    = row;
                len  = len_u;
                swap = 1'b1;
            end
            default: begin
                j = '0;
            end
        endcase
    end

    assign d        = OW'(1) << ctl.lod;
    assign jm1      = j - RW'(1);
    assign k_same_d = OW'(jm1 >> 1) << ctl.lod;
    assign k4_d     = OW'(j >> 2) << ctl.lod;

    always_comb begin
        xb = '0;
        u  = S_O;
        v  = S_O;
        if (rel == REL_SAME) begin
            if (j != '0) begin
                u = S_O - d - k_same_d;
                v = jm1[0] ? S_O : (S_O - d);
            end
        end else if (j >= len - RW'(1)) begin
            // closing vertex at the far corner
            u = '0;
            v = S_O;
        end else if (rel == REL_FINER) begin
            xb = S_O - d - k4_d;
            case (j[1:0])
                2'd0: begin
                    u = xb + d;
                    v = S_O;
                end
                2'd2: begin
                    u = xb + (d >> 1);
                    v = S_O;
                end
                default: begin
                    u = xb;
                    v = S_O - d;
                end
            endcase
        end else begin
            xb = S_O - (d << 1) - (k4_d << 1);
            case (j[1:0])
                2'd0, 2'd2: begin
                    u = xb + (d << 1);
                    v = S_O;
                end
                2'd1: begin
                    u = xb + d;
                    v = S_O - d;
                end
                default: begin
                    u = xb;
                    v = S_O - d;
                end
            endcase
        end
    end

    assign x = swap ? v : u;
    assign z = swap ? u : v;

endmodule

`default_nettype wire

>>> rtl/terrain_patch_strip_index_generator.sv
// Terrain patch strip index generator.
// Depends on tpsig_pkg, tpsig_seq, tpsig_body, tpsig_edge and the defines header.
//
// Usage:
//   Configuration: cfg_wr_en writes cfg_wdata into the register chosen by
//   cfg_addr (0 x origin, 1 z origin) at the clock edge; write only while idle.
//   Input words (s_*): s_tuser is the opcode (0 start, 1 next); a start word
//   carries the level and the right/upper neighbour relations in s_tdata.
//   Every accepted input word yields exactly one output word (m_*): a grid
//   coordinate pair in m_tdata, m_tlast on the final vertex of a patch, and
//   a status in m_tuser (0 vertex, 1 nothing to draw, 2 no active sequence).
//   The word is registered at the accepting edge, so m_tvalid rises right
//   after it; one word per cycle is sustained while m_tready stays high,
//   as all of the vertex logic lies between the sequencer and output registers.
//   If the receiver stalls, the output register holds its word and s_tready
//   drops until it is taken; a word is still accepted in the cycle it leaves.
//   Reset (aresetn low, synchronous) clears the origins, drops any sequence
//   and empties the output register.
`default_nettype none

`include "terrain_patch_strip_index_generator_defines.svh"

module terrain_patch_strip_index_generator
    import tpsig_pkg::*;
#(
    parameter int EDGE_SQUARES = 16,
    parameter int LEVELS       = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [ORIGIN_W-1:0]   cfg_wdata,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [1:0] lod, [3:2] right_relation, [5:4] upper_relation, [7:6] zero
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // [0] opcode
    input  wire logic                  s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [12:0] x_coord, [25:13] z_coord, [31:26] zero
    output logic      [M_TDATA_W-1:0]  m_tdata,
    output logic                       m_tlast,
    // [1:0] status
    output logic      [STATUS_W-1:0]   m_tuser
);

    localparam int OW = $clog2(EDGE_SQUARES + 1);
    localparam int RW = $clog2(2 * EDGE_SQUARES + 2);

    logic [ORIGIN_W-1:0] x_origin_reg;
    logic [ORIGIN_W-1:0] z_origin_reg;

    logic                m_tvalid_reg;
    logic [COORD_W-1:0]  m_x_reg, m_x_next;
    logic [COORD_W-1:0]  m_z_reg, m_z_next;
    logic                m_last_reg;
    logic [STATUS_W-1:0] m_status_reg;

    logic                go;
    seq_ctl_t            ctl;
    logic [OW-1:0]       col;
    logic [RW-1:0]       row;
    logic [RW-1:0]       len_r;
    logic [RW-1:0]       len_u;
    logic [STATUS_W-1:0] status;
    logic                last;
    logic [OW-1:0]       body_u, body_v;
    logic [OW-1:0]       edge_x, edge_z;
    logic                use_body;
    logic [OW-1:0]       off_x, off_z;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign go       = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_origin_reg <= '0;
            z_origin_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_X_ORIGIN: x_origin_reg <= cfg_wdata;
                REG_Z_ORIGIN: z_origin_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tpsig_seq #(
        .EDGE_SQUARES (EDGE_SQUARES),
        .LEVELS       (LEVELS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go        (go),
        .opcode    (s_tuser),
        .lod       (s_tdata[1:0]),
        .right_rel (s_tdata[3:2]),
        .upper_rel (s_tdata[5:4]),
        .ctl       (ctl),
        .col       (col),
        .row       (row),
        .len_r     (len_r),
        .len_u     (len_u),
        .status    (status),
        .last      (last)
    );

    tpsig_body #(
        .EDGE_SQUARES (EDGE_SQUARES)
    ) u_body (
        .ctl (ctl),
        .col (col),
        .row (row),
        .u   (body_u),
        .v   (body_v)
    );

    tpsig_edge #(
        .EDGE_SQUARES (EDGE_SQUARES)
    ) u_edge (
        .ctl   (ctl),
        .row   (row),
        .len_r (len_r),
        .len_u (len_u),
        .x     (edge_x),
        .z     (edge_z)
    );

    assign use_body = (ctl.section == SEC_BODY) || (ctl.section == SEC_LINK_R && !ctl.phase);
    assign off_x    = use_body ? body_u : edge_x;
    assign off_z    = use_body ? body_v : edge_z;

    always_comb begin
        if (status == ST_VERTEX) begin
            m_x_next = COORD_W'(x_origin_reg) + COORD_W'(off_x);
            m_z_next = COORD_W'(z_origin_reg) + COORD_W'(off_z);
        end else begin
            m_x_next = '0;
            m_z_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            m_x_reg      <= m_x_next;
            m_z_reg      <= m_z_next;
            m_last_reg   <= last;
            m_status_reg <= status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - 2 * COORD_W)'(0), m_z_reg, m_x_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_status_reg;

    `TPSIG_ASSERT(a_status_clears, aclk, aresetn, m_tvalid && m_tuser != ST_VERTEX |-> m_tdata == '0 && !m_tlast)
    `TPSIG_ASSERT(a_accept_shows, aclk, aresetn, s_tvalid && s_tready |=> m_tvalid)
    `TPSIG_ASSERT_NEVER(a_stall_blocks, aclk, aresetn, m_tvalid && !m_tready && s_tready)

endmodule

`default_nettype wire

>>> tb/patch_vertex_checker.sv
// Vertex checker for the terrain patch strip index generator testbench.
// Watches the config port and both stream channels; needs tpsig_pkg only.
`timescale 1ns / 1ps

module patch_vertex_checker
    import tpsig_pkg::*;
#(
    parameter int EDGE_SQ     = 16,
    parameter int LEVEL_COUNT = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ORIGIN_W-1:0]   cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tlast,
    input  logic [STATUS_W-1:0]   m_tuser,
    output int                    fail_count,
    output int                    open_words
);

    typedef struct packed {
        logic [COORD_W-1:0]  x_coord;
        logic [COORD_W-1:0]  z_coord;
        logic                last;
        logic [STATUS_W-1:0] status;
    } patch_vertex_t;

    patch_vertex_t pending_vertices[$];

    // shadow of the generator state
    logic [ORIGIN_W-1:0] x_org, z_org;
    logic [LOD_W-1:0]    level_q;
    logic [REL_W-1:0]    right_q, upper_q;
    sect_t               part_q;
    int unsigned         col_q, row_q;
    logic                phase_q;
    logic                busy_q;

    initial begin
        fail_count = 0;
        open_words = 0;
    end

    function automatic int unsigned step_size();
        return 1 << level_q;
    endfunction

    function automatic int unsigned span();
        return EDGE_SQ >> level_q;
    endfunction

    function automatic int unsigned edge_words(input logic [REL_W-1:0] rel);
        if (rel == REL_SAME) return 2 * span() + 1;
        if (rel == REL_FINER) return 4 * span() + 1;
        return 4 * (EDGE_SQ >> (level_q + 1)) + 1;
    endfunction

    task automatic body_xy(input int unsigned a, input int unsigned r, input logic ph,
                           output int unsigned u, output int unsigned v);
        int unsigned d;
        d = step_size();
        if (r < span()) begin
            u = a * d + (ph ? d : 0);
            v = EDGE_SQ - d - r * d;
        end else begin
            u = a * d + d;
            v = ph ? EDGE_SQ - d : 0;
        end
    endtask

    // u runs along the edge, v across it (right edge orientation)
    task automatic edge_xy(input logic [REL_W-1:0] rel, input int unsigned j,
                           output int unsigned u, output int unsigned v);
        int unsigned d, k, ph, x;
        d = step_size();
        if (rel == REL_SAME) begin
            if (j == 0) begin
                u = EDGE_SQ;
                v = EDGE_SQ;
            end else begin
                k = (j - 1) >> 1;
                ph = (j - 1) & 1;
                u = EDGE_SQ - d - k * d;
                v = ph ? EDGE_SQ : EDGE_SQ - d;
            end
        end else if (j >= edge_words(rel) - 1) begin
            u = 0;
            v = EDGE_SQ;
        end else begin
            k = j >> 2;
            ph = j & 3;
            if (rel == REL_FINER) begin
                x = EDGE_SQ - d - k * d;
                case (ph)
                    0: begin u = x + d; v = EDGE_SQ; end
                    2: begin u = x + (d >> 1); v = EDGE_SQ; end
                    default: begin u = x; v = EDGE_SQ - d; end
                endcase
            end else begin
                x = EDGE_SQ - 2 * d - 2 * k * d;
                case (ph)
                    0, 2: begin u = x + 2 * d; v = EDGE_SQ; end
                    1: begin u = x + d; v = EDGE_SQ - d; end
                    default: begin u = x; v = EDGE_SQ - d; end
                endcase
            end
        end
    endtask

    // body walks columns; every column but the last ends in a degenerate row
    task automatic advance_body();
        int unsigned n;
        n = span();
        if (!phase_q) begin
            phase_q = 1'b1;
        end else begin
            phase_q = 1'b0;
            if (row_q + 1 < n) begin
                row_q = row_q + 1;
            end else if (row_q + 1 == n) begin
                if (col_q + 2 < n) begin
                    row_q = n;
                end else begin
                    part_q = SEC_LINK_R;
                    row_q = 0;
                    col_q = 0;
                end
            end else begin
                col_q = col_q + 1;
                row_q = 0;
            end
        end
    endtask

    task automatic predict_vertex(input logic op, input logic [LOD_W-1:0] lod,
                                  input logic [REL_W-1:0] rr, input logic [REL_W-1:0] ur,
                                  output patch_vertex_t res);
        int unsigned x, z;
        logic [LOD_W-1:0] lvl;
        logic fin;
        x = 0;
        z = 0;
        fin = 1'b0;
        res = '0;
        if (op == OP_START) begin
            lvl = lod;
            if (lvl > LEVEL_COUNT - 1) lvl = LOD_W'(LEVEL_COUNT - 1);
            level_q = lvl;
            right_q = rr;
            upper_q = ur;
            part_q = SEC_BODY;
            col_q = 0;
            row_q = 0;
            phase_q = 1'b0;
            busy_q = 1'b0;
            // finest level cannot stitch to an even finer neighbour
            if ((lvl == 0 && (rr == REL_FINER || ur == REL_FINER)) || span() < 2)
                res.status = ST_EMPTY;
            else
                busy_q = 1'b1;
        end else if (!busy_q) begin
            res.status = ST_IDLE;
        end
        if (busy_q) begin
            case (part_q)
                SEC_BODY: begin
                    body_xy(col_q, row_q, phase_q, x, z);
                    advance_body();
                end
                SEC_LINK_R: begin
                    if (!phase_q) begin
                        body_xy(span() - 2, span() - 1, 1'b1, x, z);
                        phase_q = 1'b1;
                    end else begin
                        edge_xy(right_q, 0, x, z);
                        phase_q = 1'b0;
                        part_q = SEC_RIGHT;
                        row_q = 0;
                    end
                end
                SEC_RIGHT: begin
                    edge_xy(right_q, row_q, x, z);
                    row_q = row_q + 1;
                    if (row_q >= edge_words(right_q)) begin
                        part_q = SEC_LINK_U;
                        row_q = 0;
                        phase_q = 1'b0;
                    end
                end
                SEC_LINK_U: begin
                    if (!phase_q) begin
                        edge_xy(right_q, edge_words(right_q) - 1, x, z);
                        phase_q = 1'b1;
                    end else begin
                        edge_xy(upper_q, 0, z, x);
                        phase_q = 1'b0;
                        part_q = SEC_UPPER;
                        row_q = 0;
                    end
                end
                SEC_UPPER: begin
                    edge_xy(upper_q, row_q, z, x);
                    row_q = row_q + 1;
                    if (row_q >= edge_words(upper_q)) begin
                        fin = 1'b1;
                        busy_q = 1'b0;
                        part_q = SEC_BODY;
                        row_q = 0;
                    end
                end
                default: ;
            endcase
            res.x_coord = COORD_W'(x_org + x);
            res.z_coord = COORD_W'(z_org + z);
            res.last = fin;
            res.status = ST_VERTEX;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin : watch
        patch_vertex_t want, fresh;
        if (!aresetn) begin
            x_org = '0;
            z_org = '0;
            level_q = '0;
            right_q = REL_SAME;
            upper_q = REL_SAME;
            part_q = SEC_BODY;
            col_q = 0;
            row_q = 0;
            phase_q = 1'b0;
            busy_q = 1'b0;
            pending_vertices.delete();
            open_words <= 0;
        end else begin
            // drain first: a word leaving now belongs to an earlier input
            if (m_tvalid && m_tready) begin
                if (pending_vertices.size() == 0) begin
                    report_mismatch("unexpected word", int'(m_tdata), 0);
                end else begin
                    want = pending_vertices.pop_front();
                    if (m_tdata[COORD_W-1:0] != want.x_coord)
                        report_mismatch("x_coord", int'(m_tdata[COORD_W-1:0]),
                                        int'(want.x_coord));
                    if (m_tdata[2*COORD_W-1:COORD_W] != want.z_coord)
                        report_mismatch("z_coord", int'(m_tdata[2*COORD_W-1:COORD_W]),
                                        int'(want.z_coord));
                    if (m_tlast != want.last)
                        report_mismatch("last", int'(m_tlast), int'(want.last));
                    if (m_tuser != want.status)
                        report_mismatch("status", int'(m_tuser), int'(want.status));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_X_ORIGIN: x_org = cfg_wdata;
                    REG_Z_ORIGIN: z_org = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_vertex(s_tuser, s_tdata[1:0], s_tdata[3:2], s_tdata[5:4], fresh);
                pending_vertices.push_back(fresh);
            end
            open_words <= pending_vertices.size();
        end
    end

endmodule

>>> tb/terrain_patch_strip_index_generator_tb.sv
// Top of the terrain patch strip index generator testbench: clock, reset, stimulus, verdict.
// Depends on tpsig_pkg, the generator RTL and patch_vertex_checker.
`timescale 1ns / 1ps

module terrain_patch_strip_index_generator_tb
    import tpsig_pkg::*;
();

    localparam int EDGE_SQ        = 16;
    localparam int LEVEL_COUNT    = 4;
    localparam int PHASE_WORDS    = 15;
    localparam int LONG_HOLD      = 60;
    localparam int WATCHDOG_LIMIT = 1000;
    // relation code 3 is decoded as coarser
    localparam logic [REL_W-1:0] REL_CODE3 = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [ORIGIN_W-1:0]   cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic [STATUS_W-1:0]   m_tuser;

    int   fail_count;
    int   open_words;
    int   words_sent;
    int   stuck_cycles;
    logic src_idle_on;
    logic sink_idle_on;
    logic long_hold_req;

    terrain_patch_strip_index_generator #(
        .EDGE_SQUARES(EDGE_SQ),
        .LEVELS      (LEVEL_COUNT)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    patch_vertex_checker #(
        .EDGE_SQ    (EDGE_SQ),
        .LEVEL_COUNT(LEVEL_COUNT)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .fail_count(fail_count),
        .open_words(open_words)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // receiver: random short stalls, or one long hold when asked
    initial begin
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 1'b0;
                m_tready = 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("terrain_patch_strip_index_generator verification failed");
                $finish;
            end
        end
    end

    function automatic int edge_len(input int n, input logic [REL_W-1:0] rel);
        if (rel == REL_SAME) return 2 * n + 1;
        if (rel == REL_FINER) return 4 * n + 1;
        return 4 * (n / 2) + 1;
    endfunction

    // vertices from start word to last mark; 0 when the start is empty
    function automatic int patch_words(input logic [LOD_W-1:0] lod,
                                       input logic [REL_W-1:0] rr, input logic [REL_W-1:0] ur);
        int n;
        n = EDGE_SQ >> lod;
        if (lod == 0 && (rr == REL_FINER || ur == REL_FINER)) return 0;
        return (n - 2) * 2 * (n + 1) + 2 * n + 2 + edge_len(n, rr) + 2 + edge_len(n, ur);
    endfunction

    task automatic send_word(input logic op, input logic [LOD_W-1:0] lod,
                             input logic [REL_W-1:0] rr, input logic [REL_W-1:0] ur);
        int gap;
        @(negedge aclk);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser = op;
        s_tdata = {2'b00, ur, rr, lod};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // the level and relation bits are don't-care on next words
    task automatic send_next();
        send_word(OP_NEXT, LOD_W'($urandom_range(0, 3)), REL_W'($urandom_range(0, 3)),
                  REL_W'($urandom_range(0, 3)));
    endtask

    task automatic run_patch(input logic [LOD_W-1:0] lod, input logic [REL_W-1:0] rr,
                             input logic [REL_W-1:0] ur, input int nexts);
        send_word(OP_START, lod, rr, ur);
        repeat (nexts) send_next();
    endtask

    task automatic random_patch();
        logic [LOD_W-1:0] lod;
        logic [REL_W-1:0] rr, ur;
        int pick, total, nexts;
        pick = $urandom_range(0, 19);
        if (pick == 0) lod = 2'd0;
        else if (pick < 5) lod = 2'd1;
        else if (pick < 12) lod = 2'd2;
        else lod = 2'd3;
        rr = REL_W'($urandom_range(0, 3));
        ur = REL_W'($urandom_range(0, 3));
        total = patch_words(lod, rr, ur);
        pick = $urandom_range(0, 19);
        if (total == 0) nexts = $urandom_range(0, 1);
        else if (lod == 0) nexts = $urandom_range(0, 40);
        else if (pick < 3) nexts = $urandom_range(0, total - 2);
        else if (pick >= 16) nexts = total - 1 + $urandom_range(1, 2);
        else nexts = total - 1;
        run_patch(lod, rr, ur, nexts);
    endtask

    task automatic wait_results_in();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (open_words != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_origin(input logic [CFG_ADDR_W-1:0] idx, input logic [ORIGIN_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    initial begin : stimulus
        logic [ORIGIN_W-1:0] xo, zo;
        int mark;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_START;
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        long_hold_req = 1'b0;
        words_sent = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: idle next, empty starts, dropped sequence, one full patch
        send_next();
        run_patch(2'd0, REL_FINER, REL_SAME, 0);
        run_patch(2'd0, REL_SAME, REL_FINER, 0);
        run_patch(2'd0, REL_FINER, REL_FINER, 1);
        run_patch(2'd0, REL_SAME, REL_COARSER, 2);
        run_patch(2'd3, REL_SAME, REL_SAME, patch_words(2'd3, REL_SAME, REL_SAME));

        for (int p = 0; p < 5; p++) begin
            wait_results_in();
            case (p)
                0: begin xo = '1; zo = '1; end
                2: begin xo = '0; zo = '0; end
                3: begin xo = '1; zo = '0; end
                default: begin xo = ORIGIN_W'($urandom); zo = ORIGIN_W'($urandom); end
            endcase
            write_origin(REG_X_ORIGIN, xo);
            write_origin(REG_Z_ORIGIN, zo);
            src_idle_on = (p == 0 || p == 1 || p == 3);
            sink_idle_on = src_idle_on;
            mark = words_sent;
            if (p == 1) long_hold_req = 1'b1;
            // one complete patch at the finest level
            if (p == 3)
                run_patch(2'd0, REL_CODE3, REL_SAME,
                          patch_words(2'd0, REL_CODE3, REL_SAME) - 1);
            while (words_sent - mark < PHASE_WORDS) begin
                random_patch();
                if (p == 2 && words_sent - mark >= PHASE_WORDS / 2 && $urandom_range(0, 3) == 0)
                    wait_results_in();
            end
        end

        wait_results_in();
        repeat (5) @(posedge aclk);
        if (fail_count == 0 && open_words == 0)
            $display("terrain_patch_strip_index_generator verification clean");
        else
            $display("terrain_patch_strip_index_generator verification failed");
        $finish;
    end

endmodule

>>> terrain_patch_strip_index_generator.f
+incdir+rtl
rtl/tpsig_pkg.sv
rtl/tpsig_seq.sv
rtl/tpsig_body.sv
rtl/tpsig_edge.sv
rtl/terrain_patch_strip_index_generator.sv
tb/patch_vertex_checker.sv
tb/terrain_patch_strip_index_generator_tb.sv
